// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define CHK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in this cycle implies consequent in the next one
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// antecedent implies consequent a fixed number of cycles later
`define CHK_DELAY(label, ante, dly, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

// ===== hdl/gtlm_pkg.sv =====
// ----------------------------------------------------------------------------
// gtlm_pkg
// shared constants for the gate input threshold logic matrix
// ----------------------------------------------------------------------------
package gtlm_pkg;

  // default sizes
  localparam int NUM_INPUTS_DEF = 6;
  localparam int NUM_GATES_DEF  = 6;
  localparam int COUNT_BITS_DEF = 16;

  // operator codes, one per gate
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_OR    = 3'd0;
  localparam logic [OP_W-1:0] OP_AND   = 3'd1;
  localparam logic [OP_W-1:0] OP_XOR   = 3'd2;
  localparam logic [OP_W-1:0] OP_ATL2  = 3'd3;
  localparam logic [OP_W-1:0] OP_MAJ   = 3'd4;

  // threshold of the at-least-two operator
  localparam int ATL_MIN = 2;

  // configuration register indexes
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_ACTIVE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_INVERT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_OPCODE = 2'd2;

endpackage

// ===== hdl/gtlm_gate_eval.sv =====
// ----------------------------------------------------------------------------
// gtlm_gate_eval
// evaluates every gate on the resolved input bits: mask, invert, popcount, op
// ----------------------------------------------------------------------------
module gtlm_gate_eval
  import gtlm_pkg::*;
#(
  parameter int NUM_INPUTS = NUM_INPUTS_DEF,
  parameter int NUM_GATES  = NUM_GATES_DEF
) (
  input  logic [NUM_INPUTS-1:0]           bits,
  input  logic [NUM_INPUTS*NUM_GATES-1:0] active,
  input  logic [NUM_INPUTS*NUM_GATES-1:0] invert,
  input  logic [OP_W*NUM_GATES-1:0]       opcodes,
  output logic [NUM_GATES-1:0]            gate_bits
);

  localparam int PC_W = $clog2(NUM_INPUTS + 1);

  // one lane per gate, each with two small popcounts
  always_comb begin
    logic [NUM_INPUTS-1:0] act;
    logic [NUM_INPUTS-1:0] inv;
    logic [NUM_INPUTS-1:0] v;
    logic [PC_W-1:0]       high;
    logic [PC_W-1:0]       total;
    logic [OP_W-1:0]       op;
    gate_bits = '0;
    for (int j = 0; j < NUM_GATES; j++) begin
      act   = active[j*NUM_INPUTS +: NUM_INPUTS];
      inv   = invert[j*NUM_INPUTS +: NUM_INPUTS];
      op    = opcodes[j*OP_W +: OP_W];
      // invert bits outside the active mask still count as high
      v     = (bits & act) ^ inv;
      high  = '0;
      total = '0;
      for (int k = 0; k < NUM_INPUTS; k++) begin
        high  = high + PC_W'(v[k]);
        total = total + PC_W'(act[k]);
      end
      case (op)
        OP_OR:   gate_bits[j] = (high != '0);
        OP_AND:  gate_bits[j] = (high == total);
        OP_XOR:  gate_bits[j] = high[0];
        OP_ATL2: gate_bits[j] = ({1'b0, high} >= (PC_W+1)'(ATL_MIN));
        OP_MAJ:  gate_bits[j] = ({high, 1'b0} > {1'b0, total});
        default: gate_bits[j] = 1'b0;
      endcase
    end
  end

endmodule

// ===== hdl/gate_inputs_threshold_logic_matrix.sv =====
// ----------------------------------------------------------------------------
// gate_inputs_threshold_logic_matrix
// normals gate inputs, counts rising edges and evaluates the logic gates
// ----------------------------------------------------------------------------
// Takes one beat per clock cycle unless stalled, and delivers one result beat
// per input beat: the beat lands in an input register, then the normaling
// ripple over the edge counters and the gate popcounts fill the result
// register. The ripple through the chain of counter muxes, one per input, sets
// the critical path. While a result waits, only an empty input register fills.
// Configuration must be written while idle; the block does not enforce it.
module gate_inputs_threshold_logic_matrix
  import gtlm_pkg::*;
#(
  parameter int NUM_INPUTS = NUM_INPUTS_DEF,
  parameter int NUM_GATES  = NUM_GATES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [NUM_INPUTS-1:0] in_connected_mask,
  input  logic [NUM_INPUTS-1:0] in_level_bits,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [NUM_INPUTS-1:0] out_input_bits,
  output logic [NUM_GATES-1:0]  out_gate_bits,
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [((NUM_INPUTS > OP_W) ? NUM_INPUTS : OP_W)*NUM_GATES-1:0] cfg_wdata
);

  localparam int MASK_W = NUM_INPUTS * NUM_GATES;
  localparam int OPS_W  = OP_W * NUM_GATES;

  // configuration registers
  logic [MASK_W-1:0] active_r;
  logic [MASK_W-1:0] invert_r;
  logic [OPS_W-1:0]  opcode_r;

  // input stage
  logic                  s1_valid_r;
  logic [NUM_INPUTS-1:0] s1_conn_r;
  logic [NUM_INPUTS-1:0] s1_lvl_r;

  // per-input state
  logic [COUNT_BITS-1:0] cnt_r   [NUM_INPUTS];
  logic [COUNT_BITS-1:0] cnt_nxt [NUM_INPUTS];
  logic [NUM_INPUTS-1:0] lv_r;
  logic [NUM_INPUTS-1:0] lv_nxt;

  // result stage
  logic                  out_valid_r;
  logic [NUM_INPUTS-1:0] out_bits_r;
  logic [NUM_GATES-1:0]  out_gates_r;
  logic [NUM_GATES-1:0]  gates;

  logic in_acc;
  logic s1_adv;

  // handshake: the input stage moves whenever the result register is free
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      invert_r <= '0;
      opcode_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ACTIVE: active_r <= cfg_wdata[MASK_W-1:0];
        REG_INVERT: invert_r <= cfg_wdata[MASK_W-1:0];
        REG_OPCODE: opcode_r <= cfg_wdata[OPS_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_conn_r <= in_connected_mask;
      s1_lvl_r  <= in_level_bits;
    end
  end

  // normaling ripple, first input to last
  always_comb begin
    // first input has nothing to normal to and holds when unplugged
    if (s1_conn_r[0]) begin
      lv_nxt[0]  = s1_lvl_r[0];
      cnt_nxt[0] = cnt_r[0] + COUNT_BITS'(s1_lvl_r[0] & ~lv_r[0]);
    end else begin
      lv_nxt[0]  = lv_r[0];
      cnt_nxt[0] = cnt_r[0];
    end
    for (int i = 1; i < NUM_INPUTS; i++) begin
      if (s1_conn_r[i]) begin
        lv_nxt[i]  = s1_lvl_r[i];
        cnt_nxt[i] = cnt_r[i] + COUNT_BITS'(s1_lvl_r[i] & ~lv_r[i]);
      end else begin
        lv_nxt[i]  = cnt_nxt[i-1][0];
        cnt_nxt[i] = {1'b0, cnt_nxt[i-1][COUNT_BITS-1:1]};
      end
    end
  end

  // state advances once per beat leaving the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lv_r <= '0;
      for (int i = 0; i < NUM_INPUTS; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (s1_adv) begin
      lv_r <= lv_nxt;
      for (int i = 0; i < NUM_INPUTS; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  // gate evaluation
  gtlm_gate_eval #(
    .NUM_INPUTS (NUM_INPUTS),
    .NUM_GATES  (NUM_GATES)
  ) u_gate_eval (
    .bits      (lv_nxt),
    .active    (active_r),
    .invert    (invert_r),
    .opcodes   (opcode_r),
    .gate_bits (gates)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_bits_r  <= lv_nxt;
      out_gates_r <= gates;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_input_bits = out_bits_r;
  assign out_gate_bits  = out_gates_r;

endmodule

// ===== hdl/gtlm_checker.sv =====
// ----------------------------------------------------------------------------
// gtlm_checker
// port-level checks on the logic matrix, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gtlm_checker
  import gtlm_pkg::*;
#(
  parameter int NUM_INPUTS = NUM_INPUTS_DEF,
  parameter int NUM_GATES  = NUM_GATES_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [NUM_INPUTS-1:0] out_input_bits,
  input logic [NUM_GATES-1:0]  out_gate_bits
);

  // a stalled result beat holds its payload
  `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_input_bits) && $stable(out_gate_bits), "result beat changed while stalled")

  // input side only backs up behind a waiting result
  `CHK_ALWAYS(a_ready_stall, in_ready || out_valid, "input stalled with empty output")

  // every accepted beat must show out_valid once through input and result registers
  `CHK_DELAY(a_latency, in_valid && in_ready, 2, out_valid, "no result two cycles after accept")

endmodule

bind gate_inputs_threshold_logic_matrix gtlm_checker #(
  .NUM_INPUTS (NUM_INPUTS),
  .NUM_GATES  (NUM_GATES)
) u_gtlm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_input_bits (out_input_bits),
  .out_gate_bits  (out_gate_bits)
);

// ===== test/matrix_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix_checker
// result scoreboard for the gate input threshold logic matrix
// ----------------------------------------------------------------------------
// Tracks the register writes and every accepted input beat, works out the
// normaled input bits and the gate bits on its own copy of the edge counters,
// and compares each result beat, field by field, with the oldest prediction.
// Hands the mismatch count and the number of open predictions to the top.
// ----------------------------------------------------------------------------
module matrix_checker
  import gtlm_pkg::*;
#(
  parameter int CFG_W = ((NUM_INPUTS_DEF > OP_W) ? NUM_INPUTS_DEF : OP_W) * NUM_GATES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [NUM_INPUTS_DEF-1:0] in_connected_mask,
  input  logic [NUM_INPUTS_DEF-1:0] in_level_bits,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [NUM_INPUTS_DEF-1:0] out_input_bits,
  input  logic [NUM_GATES_DEF-1:0]  out_gate_bits,
  input  logic                      cfg_wr_en,
  input  logic [REG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_wdata,
  output int                        mismatch_count,
  output int                        pending_count,
  output int                        results_checked
);

  localparam int N_IN   = NUM_INPUTS_DEF;
  localparam int N_GATE = NUM_GATES_DEF;
  localparam int CNT_W  = COUNT_BITS_DEF;

  typedef struct packed {
    logic [N_IN-1:0]   input_bits;
    logic [N_GATE-1:0] gate_bits;
  } tick_result_t;

  tick_result_t     predicted_q[$];

  // own copy of the registers and of the counter state
  logic [CFG_W-1:0] active_r;
  logic [CFG_W-1:0] invert_r;
  logic [CFG_W-1:0] opcode_r;
  logic [CNT_W-1:0] edge_cnt [N_IN];
  logic [N_IN-1:0]  last_lvl;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // one gate: masked and inverted popcount, then its operator
  function automatic logic gate_out(input int j, input logic [N_IN-1:0] bits);
    logic [N_IN-1:0] act;
    logic [N_IN-1:0] inv;
    logic [OP_W-1:0] op;
    int              total;
    int              high;
    act   = active_r[j*N_IN +: N_IN];
    inv   = invert_r[j*N_IN +: N_IN];
    op    = opcode_r[j*OP_W +: OP_W];
    total = $countones(act);
    // invert bits outside the active mask still count as high
    high  = $countones((bits & act) ^ inv);
    case (op)
      OP_OR:   return high > 0;
      OP_AND:  return high == total;
      OP_XOR:  return (high % 2) == 1;
      OP_ATL2: return high >= ATL_MIN;
      OP_MAJ:  return 2 * high > total;
      default: return 1'b0;
    endcase
  endfunction

  // normaling ripple, first input to last, then the gates
  task automatic resolve_tick(input logic [N_IN-1:0] conn, input logic [N_IN-1:0] lvl,
                              output tick_result_t res);
    logic [CNT_W-1:0] prev;
    for (int i = 0; i < N_IN; i++) begin
      if (conn[i]) begin
        if (lvl[i] && !last_lvl[i]) edge_cnt[i] = edge_cnt[i] + 1'b1;
        last_lvl[i] = lvl[i];
      end else if (i > 0) begin
        prev        = edge_cnt[i-1];
        last_lvl[i] = prev[0];
        edge_cnt[i] = prev >> 1;
      end
      // an unconnected first input keeps its level and counter
    end
    res.input_bits = last_lvl;
    for (int j = 0; j < N_GATE; j++) res.gate_bits[j] = gate_out(j, last_lvl);
  endtask

  always @(posedge clk) begin
    tick_result_t res;
    tick_result_t want;
    if (!rst_n) begin
      active_r = '0;
      invert_r = '0;
      opcode_r = '0;
      last_lvl = '0;
      for (int i = 0; i < N_IN; i++) edge_cnt[i] = '0;
      predicted_q.delete();
    end else begin
      // register writes; the spare index is ignored
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_ACTIVE: active_r = cfg_wdata;
          REG_INVERT: invert_r = cfg_wdata;
          REG_OPCODE: opcode_r = cfg_wdata;
          default: ;
        endcase
      end
      // result beat against the oldest prediction
      if (out_valid && out_ready) begin
        if (predicted_q.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing pending: input %h gate %h",
                                    out_input_bits, out_gate_bits));
        end else begin
          want = predicted_q.pop_front();
          results_checked++;
          if (out_input_bits !== want.input_bits)
            report_mismatch($sformatf("result %0d input_bits got %h expected %h",
                                      results_checked, out_input_bits, want.input_bits));
          if (out_gate_bits !== want.gate_bits)
            report_mismatch($sformatf("result %0d gate_bits got %h expected %h",
                                      results_checked, out_gate_bits, want.gate_bits));
        end
      end
      // input beat makes a new prediction
      if (in_valid && in_ready) begin
        resolve_tick(in_connected_mask, in_level_bits, res);
        predicted_q.push_back(res);
      end
    end
    pending_count <= predicted_q.size();
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// testbench top for the gate input threshold logic matrix
// ----------------------------------------------------------------------------
// Drives directed beats for first-input hold, the normaling chain, every
// operator, reserved operator codes and invert bits outside the active mask,
// then random beats under several register settings and three idling mixes.
// The checker beside the block does all comparing.
// ----------------------------------------------------------------------------
module tb;
  import gtlm_pkg::*;

  localparam int N_IN   = NUM_INPUTS_DEF;
  localparam int N_GATE = NUM_GATES_DEF;
  localparam int CFG_W  = ((N_IN > OP_W) ? N_IN : OP_W) * N_GATE;

  localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [OP_W-1:0]      OP_RSVD5  = 3'd5;
  localparam logic [OP_W-1:0]      OP_RSVD6  = 3'd6;
  localparam logic [OP_W-1:0]      OP_RSVD7  = 3'd7;

  localparam int CYCLE_LIMIT       = 800000;
  localparam int ITEMS_PER_SETTING = 215;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [N_IN-1:0]   in_connected_mask;
  logic [N_IN-1:0]   in_level_bits;
  logic              out_valid;
  logic              out_ready;
  logic [N_IN-1:0]   out_input_bits;
  logic [N_GATE-1:0] out_gate_bits;
  logic              cfg_wr_en;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;

  int mismatch_count;
  int pending_count;
  int results_checked;
  int send_idle_pct;
  int recv_idle_pct;
  int beats_sent;
  int settings_used;
  int cycle_cnt;

  gate_inputs_threshold_logic_matrix dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_connected_mask (in_connected_mask),
    .in_level_bits     (in_level_bits),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_input_bits    (out_input_bits),
    .out_gate_bits     (out_gate_bits),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  matrix_checker #(.CFG_W(CFG_W)) chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_connected_mask (in_connected_mask),
    .in_level_bits     (in_level_bits),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_input_bits    (out_input_bits),
    .out_gate_bits     (out_gate_bits),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .mismatch_count    (mismatch_count),
    .pending_count     (pending_count),
    .results_checked   (results_checked)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side back-pressure
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("watchdog expired after %0d cycles, %0d results still open",
             cycle_cnt, pending_count);
    $display("TB_ERROR");
    $finish;
  end

  // one input beat, then random sender idling
  task automatic send_tick(input logic [N_IN-1:0] conn, input logic [N_IN-1:0] lvl);
    in_valid          <= 1'b1;
    in_connected_mask <= conn;
    in_level_bits     <= lvl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // stop sending and wait for every predicted result
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // back-to-back register writes while idle
  task automatic program_regs(input logic [CFG_W-1:0] act, input logic [CFG_W-1:0] inv,
                              input logic [CFG_W-1:0] ops, input bit poke_spare);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_ACTIVE;
    cfg_wdata <= act;
    @(posedge clk);
    cfg_index <= REG_INVERT;
    cfg_wdata <= inv;
    @(posedge clk);
    cfg_index <= REG_OPCODE;
    cfg_wdata <= ops;
    @(posedge clk);
    if (poke_spare) begin
      cfg_index <= REG_SPARE;
      cfg_wdata <= '1;
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  task automatic program_random;
    logic [63:0]      raw;
    logic [CFG_W-1:0] act;
    logic [CFG_W-1:0] inv;
    logic [CFG_W-1:0] ops;
    raw = {$urandom, $urandom};
    act = raw[CFG_W-1:0];
    case ($urandom_range(7))
      0, 1: act = '1;
      2:    act = '0;
      default: ;
    endcase
    raw = {$urandom, $urandom};
    inv = raw[CFG_W-1:0];
    case ($urandom_range(7))
      0, 1: inv = '0;
      2:    inv = '1;
      default: ;
    endcase
    raw = {$urandom, $urandom};
    ops = raw[CFG_W-1:0];
    // mostly defined operators, junk in the unused upper bits
    if ($urandom_range(3) != 0) begin
      for (int j = 0; j < N_GATE; j++) ops[j*OP_W +: OP_W] = OP_W'($urandom_range(OP_MAJ));
    end else if ($urandom_range(1) == 0) begin
      ops = '1;
    end
    program_regs(act, inv, ops, 1'b0);
  endtask

  // random beat, biased so the first input keeps counting
  task automatic random_tick;
    logic [N_IN-1:0] conn;
    case ($urandom_range(3))
      0:       conn = '1;
      1:       conn = N_IN'($urandom);
      default: conn = N_IN'($urandom | 1);
    endcase
    send_tick(conn, N_IN'($urandom));
  endtask

  task automatic run_phase(input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int k = 0; k < 2; k++) begin
      drain;
      program_random;
      for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
        // pause mid-setting until everything has come back
        if (k == 0 && n == ITEMS_PER_SETTING / 2) drain;
        random_tick;
      end
    end
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_connected_mask <= '0;
    in_level_bits     <= '0;
    cfg_wr_en         <= 1'b0;
    cfg_index         <= REG_ACTIVE;
    cfg_wdata         <= '0;
    send_idle_pct     = 0;
    recv_idle_pct     = 0;
    beats_sent        = 0;
    settings_used     = 1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: first input unconnected, edges, full normaling chain
    send_tick(6'b000000, 6'b000000);
    send_tick(6'b111111, 6'b111111);
    send_tick(6'b111111, 6'b000000);
    send_tick(6'b111111, 6'b111111);
    send_tick(6'b000000, 6'b111111);

    // one gate per operator plus a reserved code, invert outside active on gate 3
    drain;
    program_regs({6'b111111, 6'b011111, 6'b111000, 6'b111111, 6'b001111, 6'b000011},
                 {6'b000000, 6'b000000, 6'b000100, 6'b000000, 6'b000001, 6'b000000},
                 CFG_W'({OP_RSVD5, OP_MAJ, OP_ATL2, OP_XOR, OP_AND, OP_OR}), 1'b0);
    send_tick(6'b111111, 6'b000000);
    send_tick(6'b111111, 6'b111111);
    send_tick(6'b000001, 6'b000001);
    send_tick(6'b000011, 6'b000010);
    send_tick(6'b010101, 6'b101010);
    send_tick(6'b101010, 6'b010101);
    send_tick(6'b111111, 6'b000111);
    send_tick(6'b111111, 6'b111000);
    send_tick(6'b111111, 6'b100001);
    send_tick(6'b111111, 6'b011110);
    send_tick(6'b100000, 6'b100000);
    send_tick(6'b000000, 6'b000000);

    // all ones everywhere, and a write to the spare index
    drain;
    program_regs('1, '1, '1, 1'b1);
    send_tick(6'b111111, 6'b111111);
    send_tick(6'b111111, 6'b000000);
    send_tick(6'b000000, 6'b000000);

    // full masks with every defined operator and the other reserved code
    drain;
    program_regs('1, '0, CFG_W'({OP_RSVD6, OP_MAJ, OP_ATL2, OP_XOR, OP_AND, OP_OR}), 1'b0);
    send_tick(6'b111111, 6'b000000);
    send_tick(6'b111111, 6'b000001);
    send_tick(6'b111111, 6'b000011);
    send_tick(6'b111111, 6'b111111);

    // random traffic under the three idling mixes
    run_phase(16, 55);
    run_phase(55, 16);
    run_phase(0, 0);

    drain;
    repeat (8) @(posedge clk);
    $display("covered %0d input beats over %0d register settings and three idling mixes",
             beats_sent, settings_used);
    $display("compared %0d result beats, %0d mismatches", results_checked, mismatch_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
